// ===== src/sme_pkg.sv =====
// shared types and constants for the streaming median estimator
package sme_pkg;
  localparam int SampleWidth = 32;
  localparam int CountWidth = 32;
  localparam int WideWidth = 2 * SampleWidth + 4;
  localparam int DivCntWidth = $clog2(WideWidth + 1);

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic [CountWidth-1:0] count_t;
  typedef logic signed [WideWidth-1:0] wide_t;

  // datapath commands
  localparam logic [3:0] CMD_NONE   = 4'd0;
  localparam logic [3:0] CMD_INGEST = 4'd1;
  localparam logic [3:0] CMD_SORT   = 4'd2;
  localparam logic [3:0] CMD_TEST   = 4'd3;
  localparam logic [3:0] CMD_DIV_A  = 4'd4;
  localparam logic [3:0] CMD_DIV_B  = 4'd5;
  localparam logic [3:0] CMD_DIV_Q  = 4'd6;
  localparam logic [3:0] CMD_DIV_L  = 4'd7;
  localparam logic [3:0] CMD_COMMIT = 4'd8;
  localparam logic [3:0] CMD_MUL_A  = 4'd9;
  localparam logic [3:0] CMD_MUL_B  = 4'd10;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] marker;
  } sme_cmd_t;

  typedef struct packed {
    logic full;
    logic warm;
    logic sort_now;
    logic move;
    logic div_busy;
  } sme_stat_t;
endpackage

// ===== src/sme_div.sv =====
// shared restoring divider: signed numerator, positive divisor, truncating quotient
module sme_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sme_pkg::wide_t num,
  input  sme_pkg::wide_t den,
  output logic busy,
  output sme_pkg::wide_t quo
);
  import sme_pkg::*;
  logic [WideWidth-1:0] mag, dv, rem, q;
  logic [DivCntWidth-1:0] cnt;
  logic neg, zero;
  logic [WideWidth:0] trial;
  assign trial = {rem[WideWidth-1:0], mag[WideWidth-1]} - {1'b0, dv};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= DivCntWidth'(WideWidth);
      mag <= num[WideWidth-1] ? -num : num;
      neg <= num[WideWidth-1];
      zero <= (den[WideWidth-1] || den == '0);
      dv <= den;
      rem <= '0;
      q <= '0;
    end else if (busy) begin
      if (!trial[WideWidth]) begin
        rem <= trial[WideWidth-1:0];
        q <= {q[WideWidth-2:0], 1'b1};
      end else begin
        rem <= {rem[WideWidth-2:0], mag[WideWidth-1]};
        q <= {q[WideWidth-2:0], 1'b0};
      end
      mag <= {mag[WideWidth-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      if (cnt == DivCntWidth'(1)) busy <= 1'b0;
    end
  end
  assign quo = zero ? '0 : (neg ? -wide_t'(q) : wide_t'(q));
endmodule

// ===== src/sme_datapath.sv =====
// marker store, sort, multiply and interpolation datapath
module sme_datapath (
  input  logic clk,
  input  logic rst,
  input  sme_pkg::sme_cmd_t cmd,
  input  sme_pkg::sample_t sample,
  output sme_pkg::sme_stat_t stat,
  output sme_pkg::sample_t median_estimate,
  output sme_pkg::sample_t lower_quartile,
  output logic estimate_valid,
  output logic count_full
);
  import sme_pkg::*;
  sample_t h [5];
  count_t p [5];
  count_t n;
  wide_t prod, qa, numr, denr;
  logic dstart, dstart_next;
  logic div_busy;
  wide_t quo;
  logic sgn;
  logic [2:0] j;
  count_t pj, pu, pd;
  count_t upc, dnc;
  sample_t hj, hu, hd;
  wide_t up, dn, d4, qn, nm1;
  logic [SampleWidth-1:0] mul_f, mul_h;
  logic [2*SampleWidth-1:0] mul_res;
  logic qn_between;
  logic swp;

  sme_div u_div (.clk, .rst, .start(dstart), .num(numr), .den(denr),
    .busy(div_busy), .quo);

  assign j = {1'b0, cmd.marker};
  always_comb begin
    pj = p[j]; pu = p[j + 3'd1]; pd = p[j - 3'd1];
    hj = h[j]; hu = h[j + 3'd1]; hd = h[j - 3'd1];
    upc = pu - pj;
    dnc = pj - pd;
    up = wide_t'(pu) - wide_t'(pj);
    dn = wide_t'(pj) - wide_t'(pd);
    // marker index is 1..3, so the product is a shift and an add
    nm1 = wide_t'(n - 1'b1);
    d4 = (j[0] ? nm1 : '0) + (j[1] ? (nm1 <<< 1) : '0) + 4 - (wide_t'(pj) <<< 2);
    qn = sgn ? wide_t'(hj) + quo : wide_t'(hj) - quo;
    qn_between = (wide_t'(hd) < qn) && (qn < wide_t'(hu));
    // heights stay sorted and the position factor is positive, so 32 x 32 unsigned
    if (cmd.op == CMD_MUL_B) begin
      mul_f = sgn ? upc - 1'b1 : upc + 1'b1;
      mul_h = hj - hd;
    end else begin
      mul_f = sgn ? dnc + 1'b1 : dnc - 1'b1;
      mul_h = hu - hj;
    end
    mul_res = mul_f * mul_h;
    dstart_next = (cmd.op == CMD_DIV_A) || (cmd.op == CMD_DIV_B) ||
                  (cmd.op == CMD_DIV_Q) || ((cmd.op == CMD_DIV_L) && !qn_between);
  end

  // a pending start counts as busy so the sequencer waits for the quotient
  assign stat = '{full: count_full,
                  warm: (n >= count_t'(5)),
                  sort_now: (n == count_t'(5)) && (p[4] == '0),
                  move: ((d4 >= 4) && (up > 1)) || ((d4 <= -4) && (dn > 1)),
                  div_busy: div_busy || dstart};
  assign estimate_valid = stat.warm;
  assign median_estimate = stat.warm ? h[2] : '0;
  assign lower_quartile = stat.warm ? h[1] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dstart <= 1'b0;
      n <= '0;
      for (int i = 0; i < 5; i++) begin
        h[i] <= '0;
        p[i] <= '0;
      end
      count_full <= 1'b0;
      swp <= 1'b0;
    end else begin
      dstart <= dstart_next;
      unique case (cmd.op)
        CMD_INGEST: begin
          count_full <= (n == '1);
          if (n != '1) begin
            n <= n + 1'b1;
            if (n < count_t'(5)) h[n[2:0]] <= sample;
            else begin
              if (sample < h[0]) h[0] <= sample;
              if (sample >= h[4]) h[4] <= sample;
              for (int i = 1; i < 5; i++)
                if (sample < h[i] || (i == 4 && sample < h[4])) p[i] <= p[i] + 1'b1;
                else if (i == 4) p[i] <= p[i] + 1'b1;
            end
          end
        end
        CMD_SORT: begin
          // odd-even transposition pass, five passes give a sorted row
          for (int i = 0; i < 4; i++)
            if (i[0] == swp && h[i] > h[i+1]) begin
              h[i] <= h[i+1];
              h[i+1] <= h[i];
            end
          swp <= ~swp;
          for (int i = 0; i < 5; i++) p[i] <= count_t'(i + 1);
        end
        CMD_TEST: sgn <= (d4 > 0);
        CMD_MUL_A: prod <= wide_t'(mul_res);
        CMD_DIV_A: begin numr <= prod; denr <= up; end
        CMD_MUL_B: begin
          qa <= quo;
          prod <= wide_t'(mul_res);
        end
        CMD_DIV_B: begin numr <= prod; denr <= dn; end
        CMD_DIV_Q: begin
          numr <= qa + quo; denr <= up + dn;
        end
        CMD_DIV_L: begin
          if (qn_between) begin
            h[j] <= sample_t'(qn);
            qa <= '0;
          end else begin
            qa <= wide_t'(1);
            numr <= sgn ? wide_t'(hu) - wide_t'(hj) : wide_t'(hj) - wide_t'(hd);
            denr <= sgn ? up : dn;
          end
        end
        CMD_COMMIT: begin
          if (qa == wide_t'(1)) h[j] <= sgn ? sample_t'(wide_t'(hj) + quo)
                                             : sample_t'(wide_t'(hj) - quo);
          p[j] <= sgn ? pj + 1'b1 : pj - 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== src/sme_ctrl.sv =====
// sequencer for one sample beat
module sme_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sme_pkg::sme_stat_t stat,
  output sme_pkg::sme_cmd_t cmd
);
  import sme_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_SORT = 4'd2, S_TEST = 4'd3,
    S_MA = 4'd4, S_DA = 4'd5, S_WA = 4'd6, S_DB = 4'd7, S_WB = 4'd8, S_WQ = 4'd9,
    S_WL = 4'd10, S_CM = 4'd11, S_OUT = 4'd12, S_MB = 4'd13, S_LIN = 4'd14;
  logic [3:0] state;
  logic [1:0] mk;
  logic [2:0] cnt;
  logic ing;
  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  always_comb begin
    cmd.marker = mk;
    cmd.op = CMD_NONE;
    unique case (state)
      S_IDLE: if (in_valid) cmd.op = CMD_INGEST;
      S_SORT: cmd.op = CMD_SORT;
      S_TEST: cmd.op = CMD_TEST;
      S_MA: cmd.op = CMD_MUL_A;
      S_DA: cmd.op = CMD_DIV_A;
      S_MB: if (!stat.div_busy) cmd.op = CMD_MUL_B;
      S_DB: cmd.op = CMD_DIV_B;
      S_WB: if (!stat.div_busy) cmd.op = CMD_DIV_Q;
      S_WQ: if (!stat.div_busy) cmd.op = CMD_DIV_L;
      S_WL: if (!stat.div_busy) cmd.op = CMD_COMMIT;
      default: ;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; mk <= 2'd1; cnt <= '0; ing <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_CHK;
        S_CHK: begin
          mk <= 2'd1; cnt <= '0;
          if (stat.sort_now) state <= S_SORT;
          else if (stat.warm && !stat.full && ing) state <= S_TEST;
          else state <= S_OUT;
          ing <= 1'b1;
        end
        S_SORT: begin
          cnt <= cnt + 1'b1;
          if (cnt == 3'd4) state <= S_OUT;
        end
        S_TEST: state <= stat.move ? S_MA : S_LIN;
        S_LIN: if (mk == 2'd3) state <= S_OUT; else begin mk <= mk + 1'b1; state <= S_TEST; end
        S_MA: state <= S_DA;
        S_DA: state <= S_MB;
        S_MB: if (!stat.div_busy) state <= S_DB;
        S_DB: state <= S_WB;
        S_WB: if (!stat.div_busy) state <= S_WQ;
        S_WQ: if (!stat.div_busy) state <= S_WL;
        S_WL: if (!stat.div_busy) state <= S_LIN;
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output open together");
  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) in_valid && in_ready |=> state == S_CHK)
    else $error("beat not started");
endmodule

// ===== src/streaming_median_estimator_top.sv =====
// top level of the five-marker streaming median estimator
// a warm-up beat only stores its sample, the fifth beat sorts the markers, and
// an update beat divides three times for each inner marker that moves
// (four divides when it falls back to the linear step)
// throughput: one beat in flight at a time; updates share one 68-step divider
// rst (synchronous, active high) clears the count and all markers to zero
module streaming_median_estimator_top (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sme_pkg::sample_t sample,
  output logic out_valid,
  input  logic out_ready,
  output sme_pkg::sample_t median_estimate,
  output sme_pkg::sample_t lower_quartile,
  output logic estimate_valid,
  output logic count_full
);
  import sme_pkg::*;
  sme_cmd_t cmd;
  sme_stat_t stat;
  // controller sequences ingest, sort and the three marker moves
  sme_ctrl u_ctrl (.clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd);
  // datapath holds markers and the divider
  sme_datapath u_dp (.clk, .rst, .cmd, .sample, .stat, .median_estimate,
    .lower_quartile, .estimate_valid, .count_full);
endmodule

// ===== dv/tb_top.sv =====
// testbench for the five-marker streaming median estimator: table and random samples
`timescale 1ns / 100ps

module tb_top;
  import sme_pkg::*;

  localparam longint CountMax = (64'd1 << CountWidth) - 1;
  localparam int RandomBeats = 900;

  // one expected result beat
  typedef struct {
    sample_t med;
    sample_t lq;
    logic    ev;
    logic    full;
  } estimate_t;

  // directed row: sample, and whether the result is typed in here
  typedef struct {
    sample_t    x;
    bit         typed;
    estimate_t  res;
  } sample_row_t;

  logic    clk;
  logic    rst;
  logic    in_valid;
  logic    in_ready;
  sample_t sample;
  logic    out_valid;
  logic    out_ready;
  sample_t median_estimate;
  sample_t lower_quartile;
  logic    estimate_valid;
  logic    count_full;

  // side band from the sender to the monitor for typed rows
  bit        beat_typed;
  estimate_t beat_res;

  estimate_t pending_estimates[$];
  int        mismatches;
  bit        stim_done;

  // predictor state
  longint samples_seen;
  longint heights[5];
  longint positions[5];

  streaming_median_estimator_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .median_estimate(median_estimate),
    .lower_quartile(lower_quartile),
    .estimate_valid(estimate_valid),
    .count_full(count_full)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // move one inner marker at most one position towards its desired spot
  function automatic void nudge_marker(int j, longint desired4);
    longint d4, up, dn, s;
    logic signed [127:0] pa, pb, pq, qn;
    d4 = desired4 - 4 * positions[j];
    up = positions[j+1] - positions[j];
    dn = positions[j] - positions[j-1];
    if (!((d4 >= 4 && up > 1) || (d4 <= -4 && dn > 1))) return;
    s = (d4 > 0) ? 1 : -1;
    pa = 128'(signed'(dn + s)) * 128'(signed'(heights[j+1] - heights[j]));
    pa = (up > 0) ? pa / 128'(signed'(up)) : 0;
    pb = 128'(signed'(up - s)) * 128'(signed'(heights[j] - heights[j-1]));
    pb = (dn > 0) ? pb / 128'(signed'(dn)) : 0;
    pq = ((up + dn) > 0) ? (pa + pb) / 128'(signed'(up + dn)) : 0;
    qn = 128'(signed'(heights[j])) + ((s > 0) ? pq : -pq);
    if (128'(signed'(heights[j-1])) < qn && qn < 128'(signed'(heights[j+1])))
      heights[j] = longint'(qn);
    else if (s > 0) begin
      if (up > 0) heights[j] += (heights[j+1] - heights[j]) / up;
    end else begin
      if (dn > 0) heights[j] -= (heights[j] - heights[j-1]) / dn;
    end
    positions[j] += s;
  endfunction

  // p-square update for one accepted sample, returns the result beat
  function automatic estimate_t predict_estimate(sample_t x_in);
    estimate_t r;
    longint x, v;
    int k, i, m;
    x = longint'(x_in);
    r.full = 1'b0;
    if (samples_seen >= CountMax) r.full = 1'b1;
    else begin
      samples_seen++;
      if (samples_seen <= 5) begin
        heights[samples_seen-1] = x;
        if (samples_seen == 5) begin
          // insertion sort of the warm-up samples
          for (i = 1; i < 5; i++) begin
            v = heights[i];
            m = i;
            while (m > 0 && heights[m-1] > v) begin
              heights[m] = heights[m-1];
              m--;
            end
            heights[m] = v;
          end
          for (i = 0; i < 5; i++) positions[i] = i + 1;
        end
      end else begin
        if (x < heights[0]) begin
          heights[0] = x;
          k = 0;
        end else if (x < heights[1]) k = 0;
        else if (x < heights[2]) k = 1;
        else if (x < heights[3]) k = 2;
        else if (x < heights[4]) k = 3;
        else begin
          heights[4] = x;
          k = 3;
        end
        for (i = k + 1; i < 5; i++) positions[i]++;
        for (i = 1; i <= 3; i++) nudge_marker(i, 4 + i * (samples_seen - 1));
      end
    end
    if (samples_seen >= 5) begin
      r.med = sample_t'(heights[2]);
      r.lq = sample_t'(heights[1]);
      r.ev = 1'b1;
    end else begin
      r.med = '0;
      r.lq = '0;
      r.ev = 1'b0;
    end
    return r;
  endfunction

  // monitor: predict on input beats, compare on output beats
  always @(posedge clk) begin
    estimate_t p, e;
    if (!rst) begin
      if (in_valid && in_ready) begin
        p = predict_estimate(sample);
        pending_estimates.push_back(beat_typed ? beat_res : p);
      end
      if (out_valid && out_ready) begin
        if (pending_estimates.size() == 0) begin
          $display("%0t: unexpected result beat med=%0d lq=%0d", $time,
                   median_estimate, lower_quartile);
          mismatches++;
        end else begin
          e = pending_estimates.pop_front();
          if (median_estimate !== e.med) begin
            $display("%0t: median_estimate exp %0d got %0d", $time, e.med,
                     median_estimate);
            mismatches++;
          end
          if (lower_quartile !== e.lq) begin
            $display("%0t: lower_quartile exp %0d got %0d", $time, e.lq,
                     lower_quartile);
            mismatches++;
          end
          if (estimate_valid !== e.ev) begin
            $display("%0t: estimate_valid exp %0b got %0b", $time, e.ev,
                     estimate_valid);
            mismatches++;
          end
          if (count_full !== e.full) begin
            $display("%0t: count_full exp %0b got %0b", $time, e.full,
                     count_full);
            mismatches++;
          end
        end
      end
    end
  end

  // offer one beat from the falling edge and hold it until taken
  task automatic offer_beat(sample_t x, bit typed, estimate_t res);
    sample     <= x;
    beat_typed <= typed;
    beat_res   <= res;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // random burst gap, sometimes none at all
  task automatic maybe_gap();
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  endtask

  function automatic sample_t random_sample(int kind);
    case (kind)
      0: return sample_t'($urandom);
      1: return sample_t'($urandom_range(0, 2000)) - 1000;
      2: return sample_t'($urandom_range(0, 16)) <<< 16;
      3: return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return sample_t'($urandom_range(0, 200000)) + 32'sh0001_0000;
    endcase
  endfunction

  // stimulus: directed table first, then random bursts
  initial begin
    sample_row_t rows[$];
    sample_row_t row;
    estimate_t none, zero_res;
    int n, kind, burst;
    zero_res = '{med: '0, lq: '0, ev: 1'b0, full: 1'b0};
    none = zero_res;
    // warm-up: outputs stay zero until five samples
    rows.push_back('{32'sh7FFF_FFFF, 1'b1, zero_res});
    rows.push_back('{32'sh8000_0000, 1'b1, zero_res});
    rows.push_back('{32'sh0000_0000, 1'b1, zero_res});
    rows.push_back('{-32'sh1, 1'b1, zero_res});
    // fifth sample sorts: max, min, 0, -1, 1 -> min,-1,0,1,max
    rows.push_back('{32'sh0000_0001, 1'b1,
                     '{med: 32'sh0, lq: -32'sh1, ev: 1'b1, full: 1'b0}});
    // ties with the bottom and the top
    rows.push_back('{32'sh8000_0000, 1'b0, none});
    rows.push_back('{32'sh7FFF_FFFF, 1'b0, none});
    rows.push_back('{32'sh7FFF_FFFF, 1'b0, none});
    rows.push_back('{32'sh0000_0000, 1'b0, none});
    rows.push_back('{32'sh5555_5555, 1'b0, none});
    rows.push_back('{32'shAAAA_AAAA, 1'b0, none});
    rows.push_back('{32'sh0001_0000, 1'b0, none});
    rows.push_back('{-32'sh0001_0000, 1'b0, none});
    rows.push_back('{32'sh0000_0002, 1'b0, none});
    rows.push_back('{32'sh0000_0003, 1'b0, none});
    rows.push_back('{32'sh4000_0000, 1'b0, none});
    rows.push_back('{32'shC000_0000, 1'b0, none});
    rows.push_back('{32'sh0000_0000, 1'b0, none});
    rows.push_back('{32'sh7FFF_FFFE, 1'b0, none});
    rows.push_back('{32'sh8000_0001, 1'b0, none});

    in_valid   = 1'b0;
    sample     = '0;
    beat_typed = 1'b0;
    beat_res   = none;
    stim_done  = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);

    foreach (rows[i]) begin
      row = rows[i];
      offer_beat(row.x, row.typed, row.res);
      maybe_gap();
    end

    // random: bursts drawn from one distribution, full-range noise mixed in
    n = 0;
    while (n < RandomBeats) begin
      kind = $urandom_range(0, 4);
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        offer_beat(($urandom_range(0, 9) == 0) ? sample_t'($urandom)
                                               : random_sample(kind), 1'b0, none);
        n++;
      end
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 30)) @(negedge clk);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: one long hold-off early on, then shifting stall patterns
  initial begin
    int hold, mode;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    // long hold so the block fills and stalls its input
    hold = 0;
    while (hold < 1500) begin
      @(negedge clk);
      hold++;
    end
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(50, 600)) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) != 0);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // reset and end of run
  initial begin
    mismatches = 0;
    samples_seen = 0;
    for (int i = 0; i < 5; i++) begin
      heights[i] = 0;
      positions[i] = 0;
    end
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done);
    while (pending_estimates.size() != 0) @(posedge clk);
    // tail: allow for a late unexpected beat
    repeat (800) @(posedge clk);
    if (mismatches == 0 && pending_estimates.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #80ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== streaming_median_estimator_top.f =====
src/sme_pkg.sv
src/sme_div.sv
src/sme_datapath.sv
src/sme_ctrl.sv
src/streaming_median_estimator_top.sv
dv/tb_top.sv
